// ===== rtl/vml_pkg.sv =====
// Shared types for the vector magnitude limiter.
`timescale 1ns / 1ps

package vml_pkg;

    // Per-stage control that each pipeline cell receives from the top level.
    typedef struct packed {
        logic en;   // stage may load this cycle
        logic vld;  // word arriving from the previous stage is valid
    } t_cell_ctl;

endpackage

// ===== rtl/vector_magnitude_limit_core.sv =====
// Top level of the vector magnitude limiter: pipeline control and cell chains.
// Usage:
// The slave stream carries one vector and its length limit in each word. The
// master stream returns the limited vector, with tuser high when the vector
// was longer than the limit and was scaled by limit / length (truncated toward
// zero). Vectors within the limit pass unchanged.
// The pipeline holds three front stages (magnitudes, products, sum of squares
// and compare), DATA_WIDTH square root cells, DATA_WIDTH divider cells and the
// output register.
// Throughput is one word per cycle while m_axis_tready is high; every stage holds
// one word and the chain of cells advances one stage each cycle unless stalled.
// Each stage loads when it is empty or the stage after it moves, so the block
// keeps accepting words into gaps while a result waits at the output.
// When the receiver stalls and every stage is full, s_axis_tready drops.
// Synchronous reset clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module vector_magnitude_limit_core #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: x_in, y_in, limit, zero fill.
    input  logic [((3*DATA_WIDTH-1+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: x_out, y_out, zero fill.
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // Fields from bit 0: was_limited.
    output logic                                  m_axis_tuser
);
    import vml_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int OW    = ((2*DATA_WIDTH+7)/8)*8;
    localparam int SQ0   = 3;
    localparam int DV0   = W + 3;
    localparam int NS    = 2*W + 4;
    localparam int LAST  = NS - 1;

    logic [NS-1:0]   r_vld;
    logic [NS-1:0]   n_en;
    logic [NS-1:0]   n_vin;
    logic [NS-1:0]   n_ld;

    logic [W-1:0]    r_xr [NS];
    logic [W-1:0]    r_yr [NS];
    logic            r_fl [2:LAST];
    logic [2*W-2:0]  r_nx [1:DV0-1];
    logic [2*W-2:0]  r_ny [1:DV0-1];
    logic [W-1:0]    r_den [DV0:LAST-2];

    logic [W-1:0]    r_mx;
    logic [W-1:0]    r_my;
    logic [W-2:0]    r_lim;
    logic [2*W-2:0]  r_sqx;
    logic [2*W-2:0]  r_sqy;
    logic [2*W-2:0]  r_lsq;
    logic [2*W-1:0]  r_sum;
    logic [W-1:0]    r_xo;
    logic [W-1:0]    r_yo;

    logic [W-1:0]    n_xi;
    logic [W-1:0]    n_yi;
    logic [2*W-1:0]  n_sum;

    logic [2*W-1:0]  s_rad  [SQ0:DV0-1];
    logic [W:0]      s_rem  [SQ0:DV0-1];
    logic [W-1:0]    s_root [SQ0:DV0-1];

    logic [W-1:0]    d_rem_x [DV0:LAST-1];
    logic [W-1:0]    d_lq_x  [DV0:LAST-1];
    logic [W-1:0]    d_rem_y [DV0:LAST-1];
    logic [W-1:0]    d_lq_y  [DV0:LAST-1];

    t_cell_ctl       n_ctl [NS];

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        n_en[LAST] = !r_vld[LAST] || m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
        n_vin[0] = s_axis_tvalid;
        for (int k = 1; k < NS; k++) begin
            n_vin[k] = r_vld[k-1];
        end
        n_ld = n_en & n_vin;
        for (int k = 0; k < NS; k++) begin
            n_ctl[k].en  = n_en[k];
            n_ctl[k].vld = n_vin[k];
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= n_vin[k];
                end
            end
        end
    end

    assign s_axis_tready = n_en[0];
    assign m_axis_tvalid = r_vld[LAST];

    // Input fields and the sum of squares.
    always_comb begin
        n_xi  = s_axis_tdata[W-1:0];
        n_yi  = s_axis_tdata[2*W-1:W];
        n_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    // Front stages: magnitudes, then products, then the exact length test.
    always_ff @(posedge i_clk) begin
        if (n_ld[0]) begin
            r_mx  <= n_xi[W-1] ? W'(-n_xi) : n_xi;
            r_my  <= n_yi[W-1] ? W'(-n_yi) : n_yi;
            r_lim <= s_axis_tdata[3*W-2:2*W];
        end
        if (n_ld[1]) begin
            r_sqx   <= (2*W-1)'({{W{1'b0}}, r_mx} * {{W{1'b0}}, r_mx});
            r_sqy   <= (2*W-1)'({{W{1'b0}}, r_my} * {{W{1'b0}}, r_my});
            r_lsq   <= (2*W-1)'({{(W+1){1'b0}}, r_lim} * {{(W+1){1'b0}}, r_lim});
            r_nx[1] <= (2*W-1)'({{W{1'b0}}, r_mx} * {{(W+1){1'b0}}, r_lim});
            r_ny[1] <= (2*W-1)'({{W{1'b0}}, r_my} * {{(W+1){1'b0}}, r_lim});
        end
        if (n_ld[2]) begin
            r_sum   <= n_sum;
            r_fl[2] <= (n_sum > {1'b0, r_lsq});
        end
    end

    // Side words that ride along with each stage.
    always_ff @(posedge i_clk) begin
        if (n_ld[0]) begin
            r_xr[0] <= n_xi;
            r_yr[0] <= n_yi;
        end
        for (int k = 1; k < NS; k++) begin
            if (n_ld[k]) begin
                r_xr[k] <= r_xr[k-1];
                r_yr[k] <= r_yr[k-1];
            end
        end
        for (int k = 3; k < NS; k++) begin
            if (n_ld[k]) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
        for (int k = 2; k < DV0; k++) begin
            if (n_ld[k]) begin
                r_nx[k] <= r_nx[k-1];
                r_ny[k] <= r_ny[k-1];
            end
        end
        if (n_ld[DV0]) begin
            r_den[DV0] <= s_root[DV0-1];
        end
        for (int k = DV0 + 1; k < LAST - 1; k++) begin
            if (n_ld[k]) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    // Square root chain, two radicand bits per cell.
    for (genvar k = SQ0; k < DV0; k++) begin : g_sqrt
        if (k == SQ0) begin : g_first
            vml_sqrt_cell #(.W(W)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (n_ctl[k]),
                .i_rad  (r_sum),
                .i_rem  ('0),
                .i_root ('0),
                .o_rad  (s_rad[k]),
                .o_rem  (s_rem[k]),
                .o_root (s_root[k])
            );
        end else begin : g_next
            vml_sqrt_cell #(.W(W)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (n_ctl[k]),
                .i_rad  (s_rad[k-1]),
                .i_rem  (s_rem[k-1]),
                .i_root (s_root[k-1]),
                .o_rad  (s_rad[k]),
                .o_rem  (s_rem[k]),
                .o_root (s_root[k])
            );
        end
    end

    // Divider chain: component * limit / length for both lanes.
    for (genvar k = DV0; k < LAST; k++) begin : g_div
        if (k == DV0) begin : g_first
            vml_div_cell #(.W(W)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (n_ctl[k]),
                .i_den   (s_root[k-1]),
                .i_rem_x ({1'b0, r_nx[k-1][2*W-2:W]}),
                .i_lq_x  (r_nx[k-1][W-1:0]),
                .i_rem_y ({1'b0, r_ny[k-1][2*W-2:W]}),
                .i_lq_y  (r_ny[k-1][W-1:0]),
                .o_rem_x (d_rem_x[k]),
                .o_lq_x  (d_lq_x[k]),
                .o_rem_y (d_rem_y[k]),
                .o_lq_y  (d_lq_y[k])
            );
        end else begin : g_next
            vml_div_cell #(.W(W)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (n_ctl[k]),
                .i_den   (r_den[k-1]),
                .i_rem_x (d_rem_x[k-1]),
                .i_lq_x  (d_lq_x[k-1]),
                .i_rem_y (d_rem_y[k-1]),
                .i_lq_y  (d_lq_y[k-1]),
                .o_rem_x (d_rem_x[k]),
                .o_lq_x  (d_lq_x[k]),
                .o_rem_y (d_rem_y[k]),
                .o_lq_y  (d_lq_y[k])
            );
        end
    end

    // Output register: restore signs on scaled words, else pass the input.
    always_ff @(posedge i_clk) begin
        if (n_ld[LAST]) begin
            if (r_fl[LAST-1]) begin
                r_xo <= r_xr[LAST-1][W-1] ? W'(-d_lq_x[LAST-1]) : d_lq_x[LAST-1];
                r_yo <= r_yr[LAST-1][W-1] ? W'(-d_lq_y[LAST-1]) : d_lq_y[LAST-1];
            end else begin
                r_xo <= r_xr[LAST-1];
                r_yo <= r_yr[LAST-1];
            end
        end
    end

    assign m_axis_tdata = OW'({r_yo, r_xo});
    assign m_axis_tuser = r_fl[LAST];

`ifndef SYNTH
    // Back pressure only when the first stage holds a word.
    a_ready_front : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_vld[0])
        else $error("input stalled with an empty first stage");

    // A zero limit must mark any nonzero vector as limited.
    a_zero_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_ld[2] && (r_lsq == '0) && (n_sum != '0)) |=> r_fl[2])
        else $error("nonzero vector not limited by a zero limit");

    // Scaling keeps the sign of each component or yields zero.
    a_sign_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ((r_xo == '0) || (r_xo[W-1] == r_xr[LAST][W-1])) &&
            ((r_yo == '0) || (r_yo[W-1] == r_yr[LAST][W-1])))
        else $error("limited component changed sign");
`endif

endmodule

// ===== rtl/vml_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per stage.
`timescale 1ns / 1ps

module vml_sqrt_cell #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  vml_pkg::t_cell_ctl  i_ctl,
    input  logic [2*W-1:0]      i_rad,
    input  logic [W:0]          i_rem,
    input  logic [W-1:0]        i_root,
    output logic [2*W-1:0]      o_rad,
    output logic [W:0]          o_rem,
    output logic [W-1:0]        o_root
);
    import vml_pkg::*;

    logic [W+2:0]   n_t;
    logic [W+2:0]   n_trial;
    logic           n_ge;
    logic [2*W-1:0] r_rad;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_root;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        n_t     = {i_rem, i_rad[2*W-1:2*W-2]};
        n_trial = {1'b0, i_root, 2'b01};
        n_ge    = (n_t >= n_trial);
    end

    // Payload registers load only when a valid word moves in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_rad  <= {i_rad[2*W-3:0], 2'b00};
            r_rem  <= n_ge ? (W+1)'(n_t - n_trial) : n_t[W:0];
            r_root <= {i_root[W-2:0], n_ge};
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== rtl/vml_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of the two lanes.
`timescale 1ns / 1ps

module vml_div_cell #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  vml_pkg::t_cell_ctl  i_ctl,
    input  logic [W-1:0]        i_den,
    input  logic [W-1:0]        i_rem_x,
    input  logic [W-1:0]        i_lq_x,
    input  logic [W-1:0]        i_rem_y,
    input  logic [W-1:0]        i_lq_y,
    output logic [W-1:0]        o_rem_x,
    output logic [W-1:0]        o_lq_x,
    output logic [W-1:0]        o_rem_y,
    output logic [W-1:0]        o_lq_y
);
    import vml_pkg::*;

    logic [W:0]   n_tx;
    logic [W:0]   n_ty;
    logic         n_gx;
    logic         n_gy;
    logic [W-1:0] r_rem_x;
    logic [W-1:0] r_lq_x;
    logic [W-1:0] r_rem_y;
    logic [W-1:0] r_lq_y;

    // Shift one numerator bit into the remainder and compare with the divisor.
    always_comb begin
        n_tx = {i_rem_x, i_lq_x[W-1]};
        n_ty = {i_rem_y, i_lq_y[W-1]};
        n_gx = (n_tx >= {1'b0, i_den});
        n_gy = (n_ty >= {1'b0, i_den});
    end

    // Quotient bits fill the low word as numerator bits leave it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && i_ctl.vld) begin
            r_rem_x <= n_gx ? W'(n_tx - {1'b0, i_den}) : n_tx[W-1:0];
            r_rem_y <= n_gy ? W'(n_ty - {1'b0, i_den}) : n_ty[W-1:0];
            r_lq_x  <= {i_lq_x[W-2:0], n_gx};
            r_lq_y  <= {i_lq_y[W-2:0], n_gy};
        end
    end

    assign o_rem_x = r_rem_x;
    assign o_lq_x  = r_lq_x;
    assign o_rem_y = r_rem_y;
    assign o_lq_y  = r_lq_y;

endmodule
